// File: hw/rtl/apnn_pkg.sv
package apnn_pkg;

  localparam int MaxPoints   = 64;
  localparam int CoordBits   = 16;
  localparam int CoordInW    = 16;
  localparam int IdxW        = $clog2(MaxPoints);
  localparam int CntW        = $clog2(MaxPoints + 1);
  localparam int SqW         = 2 * CoordBits;
  localparam int DistW       = SqW + 1;
  localparam int DrainCycles = 4;
  localparam int DrainW      = $clog2(DrainCycles);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IdxW-1:0]             idx_t;
  typedef logic [CntW-1:0]             cnt_t;
  typedef logic [DistW-1:0]            dist_t;

  // tag travelling with one candidate through the distance pipeline
  typedef struct packed {
    logic vld;
    idx_t idx;
  } tag_t;

endpackage

// File: hw/rtl/apnn_dist.sv
module apnn_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  apnn_pkg::tag_t  tag_i,
  input  apnn_pkg::coord_t cand_x_i,
  input  apnn_pkg::coord_t cand_y_i,
  input  apnn_pkg::coord_t ref_x_i,
  input  apnn_pkg::coord_t ref_y_i,
  output apnn_pkg::tag_t  tag_o,
  output apnn_pkg::dist_t dist_o
);

  logic signed [apnn_pkg::CoordBits:0] diff_x, diff_y;
  logic [apnn_pkg::CoordBits:0]        abs_x, abs_y;

  apnn_pkg::tag_t                    tag_a_q, tag_b_q, tag_c_q;
  logic [apnn_pkg::CoordBits-1:0]    dx_q, dy_q;
  logic [apnn_pkg::SqW-1:0]          sqx_q, sqy_q;
  apnn_pkg::dist_t                   dist_q;

  always_comb begin
    diff_x = {cand_x_i[apnn_pkg::CoordBits-1], cand_x_i}
           - {ref_x_i[apnn_pkg::CoordBits-1], ref_x_i};
    diff_y = {cand_y_i[apnn_pkg::CoordBits-1], cand_y_i}
           - {ref_y_i[apnn_pkg::CoordBits-1], ref_y_i};
    abs_x  = diff_x[apnn_pkg::CoordBits] ? unsigned'(-diff_x) : unsigned'(diff_x);
    abs_y  = diff_y[apnn_pkg::CoordBits] ? unsigned'(-diff_y) : unsigned'(diff_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  // abs difference, squares, sum: one register after each step
  always_ff @(posedge clk_i) begin
    dx_q   <= abs_x[apnn_pkg::CoordBits-1:0];
    dy_q   <= abs_y[apnn_pkg::CoordBits-1:0];
    sqx_q  <= dx_q * dx_q;
    sqy_q  <= dy_q * dy_q;
    dist_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  assign tag_o  = tag_c_q;
  assign dist_o = dist_q;

endmodule

// File: hw/rtl/all_pairs_nearest_neighbor_2d.sv
// Brute-force nearest neighbor over up to 64 two-dimensional points. Each accepted item
// (start_i high while busy_o is low) stores one point; points past the 64th are
// dropped. The item with final_point_i set starts the search, and busy_o stays high
// until it ends. For every stored point, in load order, one result is shown for a
// single cycle with strobe_o: the index of the nearest other point (lowest index on a
// tie) and the squared distance; run_end_o marks the last one. The receiver cannot
// stall, so every strobed result must be taken. For each point the search makes one
// memory read of the reference, then one candidate read per cycle from the point
// memory's read port through the shared distance pipeline, then a pipeline drain and
// one result.
module all_pairs_nearest_neighbor_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [apnn_pkg::CoordInW-1:0] coord_x_i,
  input  logic [apnn_pkg::CoordInW-1:0] coord_y_i,
  input  logic                          final_point_i,
  output logic                          strobe_o,
  output logic [apnn_pkg::IdxW-1:0]     point_number_o,
  output logic [apnn_pkg::IdxW-1:0]     neighbor_number_o,
  output logic                          neighbor_found_o,
  output logic [apnn_pkg::DistW-1:0]    squared_distance_o,
  output logic                          run_end_o
);

  typedef enum logic [2:0] {
    StLoad,
    StFetch,
    StLatch,
    StScan,
    StDrain,
    StEmit
  } state_e;

  state_e                         state_q;
  apnn_pkg::cnt_t                 count_q;
  apnn_pkg::idx_t                 i_q, j_q;
  logic [apnn_pkg::DrainW-1:0]    drain_q;
  apnn_pkg::coord_t               ref_x_q, ref_y_q;
  apnn_pkg::idx_t                 best_idx_q;
  apnn_pkg::dist_t                best_q;
  logic                           found_q;
  apnn_pkg::tag_t                 rd_tag_q;

  logic [2*apnn_pkg::CoordBits-1:0] mem [apnn_pkg::MaxPoints];
  logic [2*apnn_pkg::CoordBits-1:0] rd_q;
  apnn_pkg::idx_t                   rd_addr;

  logic            accept;
  logic            last_j, last_i;
  apnn_pkg::tag_t  dist_tag;
  apnn_pkg::dist_t cand_dist;
  logic            take_cand;

  assign accept  = start_i && (state_q == StLoad);
  assign last_j  = ({1'b0, j_q} == apnn_pkg::CntW'(count_q - 1'b1));
  assign last_i  = ({1'b0, i_q} == apnn_pkg::CntW'(count_q - 1'b1));
  assign rd_addr = (state_q == StFetch) ? i_q : j_q;
  assign take_cand = dist_tag.vld && (!found_q || cand_dist < best_q);

  // point memory: one write port for loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && count_q < apnn_pkg::CntW'(apnn_pkg::MaxPoints)) begin
      mem[count_q[apnn_pkg::IdxW-1:0]] <= {coord_x_i[apnn_pkg::CoordBits-1:0],
                                           coord_y_i[apnn_pkg::CoordBits-1:0]};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      i_q        <= '0;
      j_q        <= '0;
      drain_q    <= '0;
      rd_tag_q   <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_q     <= '0;
      ref_x_q    <= '0;
      ref_y_q    <= '0;
    end else begin
      rd_tag_q <= '0;
      if (take_cand) begin
        found_q    <= 1'b1;
        best_q     <= cand_dist;
        best_idx_q <= dist_tag.idx;
      end
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (count_q < apnn_pkg::CntW'(apnn_pkg::MaxPoints)) begin
              count_q <= count_q + 1'b1;
            end
            if (final_point_i) begin
              i_q     <= '0;
              state_q <= StFetch;
            end
          end
        end
        StFetch: state_q <= StLatch;
        StLatch: begin
          ref_x_q    <= rd_q[2*apnn_pkg::CoordBits-1:apnn_pkg::CoordBits];
          ref_y_q    <= rd_q[apnn_pkg::CoordBits-1:0];
          j_q        <= '0;
          found_q    <= 1'b0;
          best_idx_q <= '0;
          best_q     <= '0;
          state_q    <= StScan;
        end
        StScan: begin
          // the point itself is read but never tagged as a candidate
          rd_tag_q <= '{vld: (j_q != i_q), idx: j_q};
          j_q      <= j_q + 1'b1;
          if (last_j) begin
            drain_q <= '0;
            state_q <= StDrain;
          end
        end
        StDrain: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == apnn_pkg::DrainW'(apnn_pkg::DrainCycles - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (last_i) begin
            count_q <= '0;
            state_q <= StLoad;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= StFetch;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  apnn_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .cand_x_i (rd_q[2*apnn_pkg::CoordBits-1:apnn_pkg::CoordBits]),
    .cand_y_i (rd_q[apnn_pkg::CoordBits-1:0]),
    .ref_x_i  (ref_x_q),
    .ref_y_i  (ref_y_q),
    .tag_o    (dist_tag),
    .dist_o   (cand_dist)
  );

  assign busy_o             = (state_q != StLoad);
  assign strobe_o           = (state_q == StEmit);
  assign point_number_o     = i_q;
  assign neighbor_number_o  = best_idx_q;
  assign neighbor_found_o   = found_q;
  assign squared_distance_o = best_q;
  assign run_end_o          = strobe_o && last_i;

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("result strobed while idle");

  a_final_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && final_point_i |=> busy_o)
    else $error("final item did not start a search");

  a_self_neighbor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && neighbor_found_o |-> neighbor_number_o != point_number_o)
    else $error("point reported as its own neighbor");

  a_lone_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !neighbor_found_o |-> squared_distance_o == '0 && run_end_o)
    else $error("lone point result malformed");

  a_end_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |=> !busy_o)
    else $error("search did not end after the last result");

endmodule
